### src/crdc_pkg.sv
// Shared types and constants for the camera ray direction colour core.
package crdc_pkg;

  localparam int DIM_W   = 13;
  localparam int PIX_W   = 12;
  localparam int VEC_W   = 48;
  localparam int COMP_W  = 16;
  localparam int CH_W    = 8;
  localparam int IDX_W   = 24;
  localparam int OFS_W   = 14;
  localparam int SCL_W   = 27;
  localparam int PROD_W  = 43;
  localparam int DIR_W   = 45;
  localparam int MAG_W   = 44;
  localparam int HALF_W  = MAG_W / 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ACC_W   = 106;
  localparam int NCOMP   = 3;
  localparam int STEPS   = CH_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_FORWARD = 3'd2,
    CFG_RIGHT   = 3'd3,
    CFG_UP      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_req_t;

  typedef struct packed {
    logic [23:0] pixel_color;
    logic [23:0] pixel_index;
  } out_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]            sum;
    logic [NCOMP-1:0][ACC_W-1:0] tgt;
    logic [NCOMP-1:0]            pos;
    logic [IDX_W-1:0]            index;
  } srch_in_t;

  typedef struct packed {
    logic [NCOMP-1:0][CH_W-1:0] level;
    logic [NCOMP-1:0]           pos;
    logic [IDX_W-1:0]           index;
  } srch_out_t;

endpackage

### src/crdc_color_search.sv
// Eight-stage digit search for floor(255 * d / |d|) on three channels.
module crdc_color_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  crdc_pkg::srch_in_t in_req,
  output logic               out_valid,
  output crdc_pkg::srch_out_t out_req
);
  import crdc_pkg::*;

  logic                        v_r   [STEPS];
  logic [SUM_W-1:0]            s_r   [STEPS];
  logic [NCOMP-1:0][ACC_W-1:0] t_r   [STEPS];
  logic [NCOMP-1:0][ACC_W-1:0] p_r   [STEPS];
  logic [NCOMP-1:0][ACC_W-1:0] q_r   [STEPS];
  logic [NCOMP-1:0][CH_W-1:0]  k_r   [STEPS];
  logic [NCOMP-1:0]            pos_r [STEPS];
  logic [IDX_W-1:0]            idx_r [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam int J = STEPS - 1 - g;
    logic                        src_v;
    logic [SUM_W-1:0]            src_s;
    logic [NCOMP-1:0][ACC_W-1:0] src_t;
    logic [NCOMP-1:0][ACC_W-1:0] src_p;
    logic [NCOMP-1:0][ACC_W-1:0] src_q;
    logic [NCOMP-1:0][CH_W-1:0]  src_k;
    logic [NCOMP-1:0]            src_pos;
    logic [IDX_W-1:0]            src_idx;
    logic [NCOMP-1:0][ACC_W-1:0] p_nxt;
    logic [NCOMP-1:0][ACC_W-1:0] q_nxt;
    logic [NCOMP-1:0][CH_W-1:0]  k_nxt;

    if (g == 0) begin : g_src_in
      assign src_v   = in_valid;
      assign src_s   = in_req.sum;
      assign src_t   = in_req.tgt;
      assign src_p   = '0;
      assign src_q   = '0;
      assign src_k   = '0;
      assign src_pos = in_req.pos;
      assign src_idx = in_req.index;
    end else begin : g_src_reg
      assign src_v   = v_r[g-1];
      assign src_s   = s_r[g-1];
      assign src_t   = t_r[g-1];
      assign src_p   = p_r[g-1];
      assign src_q   = q_r[g-1];
      assign src_k   = k_r[g-1];
      assign src_pos = pos_r[g-1];
      assign src_idx = idx_r[g-1];
    end

    always_comb begin
      logic [ACC_W-1:0] trial;
      logic [ACC_W-1:0] s_ext;
      s_ext = ACC_W'(src_s);
      p_nxt = src_p;
      q_nxt = src_q;
      k_nxt = src_k;
      for (int c = 0; c < NCOMP; c++) begin
        trial = src_p[c] + (src_q[c] << (J + 1)) + (s_ext << (2 * J));
        if (trial <= src_t[c]) begin
          p_nxt[c] = trial;
          q_nxt[c] = src_q[c] + (s_ext << J);
          k_nxt[c] = src_k[c] | (CH_W'(1) << J);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[g]   <= src_s;
        t_r[g]   <= src_t;
        p_r[g]   <= p_nxt;
        q_r[g]   <= q_nxt;
        k_r[g]   <= k_nxt;
        pos_r[g] <= src_pos;
        idx_r[g] <= src_idx;
      end
    end
  end

  assign out_valid     = v_r[STEPS-1];
  assign out_req.level = k_r[STEPS-1];
  assign out_req.pos   = pos_r[STEPS-1];
  assign out_req.index = idx_r[STEPS-1];

endmodule

### src/camera_ray_direction_color_core.sv
// Top level: pinhole camera primary ray direction packed as an RGB888 colour.
//
//  channel | ports                                  | role
//  --------+----------------------------------------+------------------------------
//  in      | in_valid, in_stall, in_data            | pixel request (x, y)
//  out     | out_valid, out_stall, out_data         | colour and framebuffer index
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// One pixel request per cycle while the output is not stalled; a result passes
// through eight arithmetic stages, eight digit stages of the colour search and
// the output register. Synchronous active-low reset clears the valid bits and
// restores the registers to 640 x 480 with zero vectors. A stalled output
// freezes the whole pipeline and raises in_stall in the same cycle.
module camera_ray_direction_color_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  crdc_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output crdc_pkg::out_req_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crdc_pkg::VEC_W-1:0]       cfg_data
);
  import crdc_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [VEC_W-1:0] fwd_r;
  logic [VEC_W-1:0] right_r;
  logic [VEC_W-1:0] up_r;

  logic en;
  logic accept;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  logic [7:0]              v_r;
  logic [IDX_W-1:0]        idx_r [8];

  logic signed [OFS_W-1:0] a1_r;
  logic signed [OFS_W-1:0] b1_r;
  logic signed [SCL_W-1:0] rs2_r;
  logic signed [SCL_W-1:0] us2_r;
  logic signed [SCL_W-1:0] wh2_r;
  logic signed [PROD_W-1:0] prod3_r [NCOMP][3];
  logic signed [DIR_W-1:0]  d4_r [NCOMP];
  logic [MAG_W-1:0]         mag5_r [NCOMP];
  logic [NCOMP-1:0]         pos5_r;
  logic [NCOMP-1:0]         pos6_r;
  logic [NCOMP-1:0]         pos7_r;
  logic [NCOMP-1:0]         pos8_r;
  logic [MAG_W-1:0]         hh6_r [NCOMP];
  logic [MAG_W-1:0]         hl6_r [NCOMP];
  logic [MAG_W-1:0]         ll6_r [NCOMP];
  logic [SQ_W-1:0]          sq7_r [NCOMP];
  logic [SUM_W-1:0]         sum8_r;
  logic [NCOMP-1:0][ACC_W-1:0] tgt8_r;

  logic signed [COMP_W-1:0] fv [NCOMP];
  logic signed [COMP_W-1:0] rv [NCOMP];
  logic signed [COMP_W-1:0] uv [NCOMP];

  srch_in_t  srch_in;
  srch_out_t srch_out;
  logic      srch_valid;

  logic     out_valid_r;
  out_req_t out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      fwd_r    <= '0;
      right_r  <= '0;
      up_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:   width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:  height_r <= cfg_data[DIM_W-1:0];
        CFG_FORWARD: fwd_r    <= cfg_data;
        CFG_RIGHT:   right_r  <= cfg_data;
        CFG_UP:      up_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (width_r == '0) ? DIM_W'(1) : width_r;
  assign h_eff = (height_r == '0) ? DIM_W'(1) : height_r;

  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      fv[c] = fwd_r[COMP_W*c +: COMP_W];
      rv[c] = right_r[COMP_W*c +: COMP_W];
      uv[c] = up_r[COMP_W*c +: COMP_W];
    end
  end

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], accept};
    end
  end

  // offsets, index
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= $signed(OFS_W'({in_data.pixel_x, 1'b1})) - $signed(OFS_W'(w_eff));
      b1_r <= $signed(OFS_W'(h_eff)) - $signed(OFS_W'({in_data.pixel_y, 1'b1}));
      idx_r[0] <= IDX_W'(25'(in_data.pixel_x) + 25'(in_data.pixel_y) * 25'(w_eff));
      for (int i = 1; i < 8; i++) begin
        idx_r[i] <= idx_r[i-1];
      end
    end
  end

  // scaled offsets
  always_ff @(posedge clk) begin
    logic signed [OFS_W-1:0] hs;
    logic signed [OFS_W-1:0] ws;
    hs = $signed(OFS_W'(h_eff));
    ws = $signed(OFS_W'(w_eff));
    if (en) begin
      rs2_r <= SCL_W'(28'(a1_r) * 28'(hs));
      us2_r <= SCL_W'(28'(b1_r) * 28'(ws));
      wh2_r <= $signed(SCL_W'(w_eff * h_eff));
    end
  end

  // component products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCOMP; c++) begin
        prod3_r[c][0] <= PROD_W'(fv[c]) * PROD_W'(wh2_r);
        prod3_r[c][1] <= PROD_W'(rv[c]) * PROD_W'(rs2_r);
        prod3_r[c][2] <= PROD_W'(uv[c]) * PROD_W'(us2_r);
      end
    end
  end

  // direction
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCOMP; c++) begin
        d4_r[c] <= DIR_W'(prod3_r[c][0]) + DIR_W'(prod3_r[c][1]) + DIR_W'(prod3_r[c][2]);
      end
    end
  end

  // magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCOMP; c++) begin
        mag5_r[c] <= MAG_W'(d4_r[c][DIR_W-1] ? -d4_r[c] : d4_r[c]);
        pos5_r[c] <= !d4_r[c][DIR_W-1] && (d4_r[c] != '0);
      end
    end
  end

  // partial squares
  always_ff @(posedge clk) begin
    if (en) begin
      pos6_r <= pos5_r;
      for (int c = 0; c < NCOMP; c++) begin
        hh6_r[c] <= MAG_W'(mag5_r[c][MAG_W-1:HALF_W]) * MAG_W'(mag5_r[c][MAG_W-1:HALF_W]);
        hl6_r[c] <= MAG_W'(mag5_r[c][MAG_W-1:HALF_W]) * MAG_W'(mag5_r[c][HALF_W-1:0]);
        ll6_r[c] <= MAG_W'(mag5_r[c][HALF_W-1:0]) * MAG_W'(mag5_r[c][HALF_W-1:0]);
      end
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      pos7_r <= pos6_r;
      for (int c = 0; c < NCOMP; c++) begin
        sq7_r[c] <= (SQ_W'(hh6_r[c]) << MAG_W) + (SQ_W'(hl6_r[c]) << (HALF_W + 1))
                    + SQ_W'(ll6_r[c]);
      end
    end
  end

  // norm squared and 255^2 scaled targets
  always_ff @(posedge clk) begin
    if (en) begin
      pos8_r <= pos7_r;
      sum8_r <= SUM_W'(sq7_r[0]) + SUM_W'(sq7_r[1]) + SUM_W'(sq7_r[2]);
      for (int c = 0; c < NCOMP; c++) begin
        tgt8_r[c] <= (ACC_W'(sq7_r[c]) << 16) - (ACC_W'(sq7_r[c]) << 9) + ACC_W'(sq7_r[c]);
      end
    end
  end

  assign srch_in.sum   = sum8_r;
  assign srch_in.tgt   = tgt8_r;
  assign srch_in.pos   = pos8_r;
  assign srch_in.index = idx_r[7];

  crdc_color_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[7]),
    .in_req    (srch_in),
    .out_valid (srch_valid),
    .out_req   (srch_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= srch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.pixel_color <= {srch_out.pos[0] ? srch_out.level[0] : CH_W'(0),
                                 srch_out.pos[1] ? srch_out.level[1] : CH_W'(0),
                                 srch_out.pos[2] ? srch_out.level[2] : CH_W'(0)};
      out_data_r.pixel_index <= srch_out.index;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
